/* rtl/der_ecdsa_signature_length_check_macros.svh */
// Assertion macros for the signature length checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef DER_ECDSA_SIGNATURE_LENGTH_CHECK_MACROS_SVH
`define DER_ECDSA_SIGNATURE_LENGTH_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsl assertion failed");

`endif

/* rtl/dsl_pkg.sv */
`default_nettype none

package dsl_pkg;

    // One byte of the encoded signature, as held in the input register.
    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } dsl_item_t;

    // One verdict, as handed from the parser to the result register.
    typedef struct packed {
        logic       accepted;
        logic [8:0] signature_length;
    } dsl_result_t;

endpackage

`default_nettype wire

/* rtl/dsl_in_stage.sv */
`default_nettype none

// Input register: holds one byte until the parser takes it.
module dsl_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dsl_pkg::dsl_item_t in_item,
    output logic                   item_valid,
    output dsl_pkg::dsl_item_t     item,
    input  wire logic              item_take
);

    logic               valid_reg;
    logic               valid_next;
    dsl_pkg::dsl_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/dsl_parser.sv */
`default_nettype none

// Parse state machine: one byte per cycle while the result register can take a verdict, at most one verdict per byte.
module dsl_parser
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         max_size,
    input  wire logic               item_valid,
    input  wire dsl_pkg::dsl_item_t item,
    output logic                    item_take,
    input  wire logic               res_ready,
    output logic                    res_valid,
    output dsl_pkg::dsl_result_t    res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_RTAG  = 3'd2;
    localparam logic [2:0] PH_RLEN  = 3'd3;
    localparam logic [2:0] PH_RBODY = 3'd4;
    localparam logic [2:0] PH_STAG  = 3'd5;
    localparam logic [2:0] PH_SLEN  = 3'd6;
    localparam logic [2:0] PH_SBODY = 3'd7;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] MIN_BODY     = 8'd64;
    localparam logic [7:0] COORD_BYTES  = 8'd32;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [8:0] total_reg, total_next;
    logic [7:0] rlen_reg,  rlen_next;
    logic [7:0] slen_reg,  slen_next;

    logic       verdict;
    logic       ok;
    logic [7:0] b;
    logic [7:0] count_inc;
    logic [9:0] sum_rs;

    assign b         = item.data_byte;
    assign item_take = item_valid && res_ready;
    assign count_inc = count_reg + 8'd1;
    // Six header bytes plus both integers, against the declared whole length.
    assign sum_rs    = {2'b00, b} + {2'b00, rlen_reg} + 10'd6;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        total_next = total_reg;
        rlen_next  = rlen_reg;
        slen_next  = slen_reg;
        verdict    = 1'b0;
        ok         = 1'b0;

        if (item.start_req)
        begin
            count_next = '0;
            total_next = '0;
            rlen_next  = '0;
            slen_next  = '0;
            if (max_size == 8'd0 || b != TAG_SEQUENCE)
            begin
                verdict = 1'b1;
            end
            else
            begin
                phase_next = PH_LEN;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_LEN:
                begin
                    // A max_size of one wraps to no upper bound.
                    if (max_size == 8'd0 || b < MIN_BODY ||
                        (max_size != 8'd1 && ({1'b0, b} + 9'd2) > {1'b0, max_size}))
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        total_next = {1'b0, b} + 9'd2;
                        phase_next = PH_RTAG;
                    end
                end
                PH_RTAG:
                begin
                    if (b != TAG_INTEGER)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RLEN;
                    end
                end
                PH_RLEN:
                begin
                    rlen_next = b;
                    if (({1'b0, b} + 9'd4) > total_reg)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = (b == 8'd0) ? PH_STAG : PH_RBODY;
                    end
                end
                PH_RBODY:
                begin
                    // Only the padding bytes beyond the 32-byte coordinate are checked.
                    if (rlen_reg > COORD_BYTES && count_reg < (rlen_reg - COORD_BYTES) &&
                        b != 8'd0)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (count_inc >= rlen_reg)
                        begin
                            phase_next = PH_STAG;
                        end
                    end
                end
                PH_STAG:
                begin
                    if (b != TAG_INTEGER)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SLEN;
                    end
                end
                PH_SLEN:
                begin
                    slen_next = b;
                    if (sum_rs > {1'b0, total_reg})
                    begin
                        verdict = 1'b1;
                    end
                    else if (b <= COORD_BYTES)
                    begin
                        verdict = 1'b1;
                        ok      = 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = PH_SBODY;
                    end
                end
                PH_SBODY:
                begin
                    if (b != 8'd0)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (count_inc >= (slen_reg - COORD_BYTES))
                        begin
                            verdict = 1'b1;
                            ok      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (verdict)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign res_valid = item_take && verdict;

    always_comb
    begin
        res.accepted         = ok;
        res.signature_length = '0;
        if (ok)
        begin
            res.signature_length = 9'd6 + {1'b0, rlen_reg} + {1'b0, slen_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            rlen_reg  <= '0;
            slen_reg  <= '0;
        end
        else if (item_take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            total_reg <= total_next;
            rlen_reg  <= rlen_next;
            slen_reg  <= slen_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dsl_out_stage.sv */
`default_nettype none

// Result register: holds a verdict until the downstream side takes it.
module dsl_out_stage
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                res_valid,
    output logic                     res_ready,
    input  wire dsl_pkg::dsl_result_t res,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dsl_pkg::dsl_result_t     out_res
);

    logic                 valid_reg;
    logic                 valid_next;
    dsl_pkg::dsl_result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* rtl/der_ecdsa_signature_length_check.sv */
// Channel   | Dir | tdata                        | tuser        | Notes
// s_axis    | in  | [7:0] data_byte              | start_req    | one byte per request
// m_axis    | out | [8:0] signature_length, pad  | accepted     | at most one per signature
// max_size  | in  | max_size_wr_data[7:0]        | -            | write when max_size_wr_en
//
// A byte is taken every cycle while s_tready is high. It is held in the input register, and its
// verdict, if it causes one, passes from there into the result register, from which the master
// side can take it.
// Reset is asynchronous and active low; it returns the parser to idle and max_size to 128.
// A stalled master side stops the parser only while the result register is full;
// the input register then holds one byte and s_tready drops.
`default_nettype none

`include "der_ecdsa_signature_length_check_macros.svh"

module der_ecdsa_signature_length_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,          // [7:0] data_byte
    input  wire logic        s_tuser,          // [0] start_req
    // Verdict out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,          // [8:0] signature_length, [15:9] zero
    output logic             m_tuser,          // [0] accepted
    // Configuration register.
    input  wire logic        max_size_wr_en,
    input  wire logic [7:0]  max_size_wr_data
);

    // The largest whole signature allowed; the user must write it only while the block is idle (not enforced here).
    logic [7:0] max_size_reg;

    dsl_pkg::dsl_item_t   in_item;
    dsl_pkg::dsl_item_t   item;
    logic                 item_valid;
    logic                 item_take;
    logic                 res_valid;
    logic                 res_ready;
    dsl_pkg::dsl_result_t res;
    dsl_pkg::dsl_result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= 8'd128;
        end
        else if (max_size_wr_en)
        begin
            max_size_reg <= max_size_wr_data;
        end
    end

    assign in_item.data_byte = s_tdata;
    assign in_item.start_req = s_tuser;

    dsl_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // The parser advances on a byte only when a verdict could be stored, so no
    // verdict is ever dropped by a full result register.
    dsl_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_size   (max_size_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    dsl_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {7'd0, out_res.signature_length};
    assign m_tuser = out_res.accepted;

    // A rejected signature never reports a length.
    `DSL_ASSERT_NOW(a_reject_zero_len, m_tvalid && !m_tuser, m_tdata[8:0] == 9'd0)
    // An accepted length never exceeds the whole-signature limit of 257 bytes.
    `DSL_ASSERT_NOW(a_accept_len_range, m_tvalid && m_tuser, m_tdata[8:0] <= 9'd257)
    // A verdict is only produced when the result register can take it.
    `DSL_ASSERT_NOW(a_no_overwrite, res_valid, res_ready && item_take)
    // A stored verdict appears on the master side in the next cycle.
    `DSL_ASSERT_NEXT(a_verdict_shows, res_valid, m_tvalid)

endmodule

`default_nettype wire
